// ===== src/xdec_pkg.sv =====
// Shared types and constants for the x86 subset instruction decoder.
// No dependencies; every other file of the block imports this package.
package xdec_pkg;

    localparam int REF_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH   = 4;
    localparam int M_TDATA_W     = 176;
    localparam int M_TUSER_W     = 3;

    // Opcode and prefix encodings
    localparam logic [7:0] REX_MASK    = 8'hF0;
    localparam logic [7:0] REX_TAG     = 8'h40;
    localparam logic [7:0] REX_RXB     = 8'h07;
    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] OP_MOV_LO   = 8'hB8;
    localparam logic [7:0] OP_MOV_HI   = 8'hBF;
    localparam logic [7:0] OP_ADD      = 8'h01;
    localparam logic [7:0] OP_SUB      = 8'h29;
    localparam logic [1:0] MOD_REG     = 2'b11;
    localparam int         REX_W_BIT   = 3;

    // Statement kinds
    localparam logic [2:0] STMT_RET    = 3'd0;
    localparam logic [2:0] STMT_CONST  = 3'd1;
    localparam logic [2:0] STMT_LOAD   = 3'd2;
    localparam logic [2:0] STMT_STORE  = 3'd3;
    localparam logic [2:0] STMT_BINOP  = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_TRUNC   = 2'd1;
    localparam logic [1:0] ERR_UNSUP   = 2'd2;
    localparam logic [1:0] ERR_UNKNOWN = 2'd3;

    // Register addresses (word index)
    localparam logic REG_FIRST_REF = 1'b0;

    typedef enum logic [3:0] {
        PH_FIRST  = 4'b0001,
        PH_OPCODE = 4'b0010,
        PH_IMM    = 4'b0100,
        PH_MODRM  = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        JOB_RET = 2'd0,
        JOB_MOV = 2'd1,
        JOB_ALU = 2'd2,
        JOB_ERR = 2'd3
    } job_kind_t;

    // One decoded instruction (or error) handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  err;
        logic [3:0]  len;
        logic [2:0]  reg_a;    // MOV target or ModR/M rm
        logic [2:0]  reg_b;    // ModR/M reg
        logic        is_sub;
        logic [63:0] imm;
        logic [31:0] ref0;
        logic [31:0] ref1;
        logic [31:0] ref2;
    } job_t;

endpackage

// ===== src/xdec_front.sv =====
// Front end: byte-serial x86 subset decoder, one byte per beat.
// Emits one job per finished instruction or error. Depends on xdec_pkg.
module xdec_front
    import xdec_pkg::*;
#(
    parameter int REF_WIDTH = REF_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        byte_accept,
    input  logic [7:0]  code_byte,
    input  logic        is_last,
    input  logic        cfg_load,
    input  logic [31:0] cfg_value,
    output logic        push,
    output job_t        job
);

    phase_t                 phase_reg, phase_next;
    logic                   wide_reg, wide_next;
    logic [2:0]             tgt_reg, tgt_next;
    logic                   sub_reg, sub_next;
    logic [2:0]             icnt_reg, icnt_next;
    logic [3:0]             len_reg, len_next;
    logic [REF_WIDTH-1:0]   ref_reg, ref_next;
    logic [63:0]            imm_reg;

    logic [3:0]             len_inc;
    logic                   in_prefix;
    logic                   push_c;
    job_t                   job_c;

    assign len_inc = (len_reg < 4'd15) ? len_reg + 4'd1 : len_reg;

    always_comb begin
        phase_next = phase_reg;
        wide_next  = wide_reg;
        tgt_next   = tgt_reg;
        sub_next   = sub_reg;
        icnt_next  = icnt_reg;
        ref_next   = ref_reg;
        push_c     = 1'b0;
        in_prefix  = (phase_reg == PH_OPCODE);
        job_c      = '0;
        job_c.len  = len_inc;
        job_c.ref0 = 32'(ref_reg);
        job_c.ref1 = 32'(ref_reg + REF_WIDTH'(1));
        job_c.ref2 = 32'(ref_reg + REF_WIDTH'(2));

        unique case (phase_reg)
            PH_IMM: begin
                if (icnt_reg == 3'd7) begin
                    push_c      = 1'b1;
                    job_c.kind  = JOB_MOV;
                    job_c.reg_a = tgt_reg;
                    job_c.imm   = {code_byte, imm_reg[55:0]};
                    ref_next    = ref_reg + REF_WIDTH'(1);
                end else if (is_last) begin
                    push_c     = 1'b1;
                    job_c.kind = JOB_ERR;
                    job_c.err  = ERR_TRUNC;
                end else begin
                    icnt_next = icnt_reg + 3'd1;
                end
            end
            PH_MODRM: begin
                push_c = 1'b1;
                if (code_byte[7:6] != MOD_REG) begin
                    job_c.kind = JOB_ERR;
                    job_c.err  = ERR_UNSUP;
                end else begin
                    job_c.kind   = JOB_ALU;
                    job_c.reg_a  = code_byte[2:0];
                    job_c.reg_b  = code_byte[5:3];
                    job_c.is_sub = sub_reg;
                    ref_next     = ref_reg + REF_WIDTH'(3);
                end
            end
            default: begin
                // first byte or opcode after REX
                if (!in_prefix && (code_byte & REX_MASK) == REX_TAG) begin
                    if (is_last) begin
                        push_c     = 1'b1;
                        job_c.kind = JOB_ERR;
                        job_c.err  = ERR_TRUNC;
                    end else if ((code_byte & REX_RXB) != 8'h00) begin
                        push_c     = 1'b1;
                        job_c.kind = JOB_ERR;
                        job_c.err  = ERR_UNSUP;
                    end else begin
                        phase_next = PH_OPCODE;
                        wide_next  = code_byte[REX_W_BIT];
                    end
                end else if (code_byte == OP_RET) begin
                    push_c = 1'b1;
                    if (in_prefix) begin
                        job_c.kind = JOB_ERR;
                        job_c.err  = ERR_UNSUP;
                    end else begin
                        job_c.kind = JOB_RET;
                    end
                end else if (code_byte >= OP_MOV_LO && code_byte <= OP_MOV_HI) begin
                    if (!(in_prefix && wide_reg)) begin
                        push_c     = 1'b1;
                        job_c.kind = JOB_ERR;
                        job_c.err  = ERR_UNSUP;
                    end else if (is_last) begin
                        push_c     = 1'b1;
                        job_c.kind = JOB_ERR;
                        job_c.err  = ERR_TRUNC;
                    end else begin
                        phase_next = PH_IMM;
                        tgt_next   = code_byte[2:0];
                        icnt_next  = 3'd0;
                    end
                end else if (code_byte == OP_ADD || code_byte == OP_SUB) begin
                    if (!(in_prefix && wide_reg)) begin
                        push_c     = 1'b1;
                        job_c.kind = JOB_ERR;
                        job_c.err  = ERR_UNSUP;
                    end else if (is_last) begin
                        push_c     = 1'b1;
                        job_c.kind = JOB_ERR;
                        job_c.err  = ERR_TRUNC;
                    end else begin
                        phase_next = PH_MODRM;
                        sub_next   = (code_byte == OP_SUB);
                    end
                end else begin
                    push_c     = 1'b1;
                    job_c.kind = JOB_ERR;
                    job_c.err  = ERR_UNKNOWN;
                end
            end
        endcase

        len_next = len_inc;
        if (push_c) begin
            // any job closes the instruction
            phase_next = PH_FIRST;
            wide_next  = 1'b0;
            tgt_next   = 3'd0;
            sub_next   = 1'b0;
            icnt_next  = 3'd0;
            len_next   = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FIRST;
            wide_reg  <= 1'b0;
            tgt_reg   <= 3'd0;
            sub_reg   <= 1'b0;
            icnt_reg  <= 3'd0;
            len_reg   <= 4'd0;
            ref_reg   <= '0;
        end else begin
            if (byte_accept) begin
                phase_reg <= phase_next;
                wide_reg  <= wide_next;
                tgt_reg   <= tgt_next;
                sub_reg   <= sub_next;
                icnt_reg  <= icnt_next;
                len_reg   <= len_next;
            end
            if (cfg_load) begin
                ref_reg <= REF_WIDTH'(cfg_value);
            end else if (byte_accept) begin
                ref_reg <= ref_next;
            end
        end
    end

    // immediate lanes are each written once before use, so no clear needed
    always_ff @(posedge aclk) begin
        if (byte_accept && phase_reg == PH_IMM) begin
            imm_reg[{icnt_reg, 3'b000} +: 8] <= code_byte;
        end
    end

    assign push = byte_accept && push_c;
    assign job  = job_c;

endmodule

// ===== src/xdec_fifo.sv =====
// Job queue between decoder front end and statement back end.
// Register array with read/write pointers and a fill count. Depends on xdec_pkg.
module xdec_fifo
    import xdec_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output job_t head_job
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== src/xdec_back.sv =====
// Back end: expands the head job into 1, 2 or 4 statement beats, one per
// cycle unless stalled, into a registered output stage. Depends on xdec_pkg.
module xdec_back
    import xdec_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  job_t                 head_job,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast
);

    logic [1:0]            step_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;
    logic                  m_tlast_reg;

    logic                  load;
    logic                  last_step;
    logic [2:0]            kind;
    logic                  has_ref;
    logic [31:0]           res_ref, op_a, op_b;
    logic [2:0]            reg_idx;
    logic                  sub;
    logic [63:0]           imm;
    logic [1:0]            err;

    always_comb begin
        kind      = STMT_RET;
        has_ref   = 1'b0;
        res_ref   = '0;
        op_a      = '0;
        op_b      = '0;
        reg_idx   = '0;
        sub       = 1'b0;
        imm       = '0;
        err       = ERR_NONE;
        last_step = 1'b1;
        unique case (head_job.kind)
            JOB_RET: ;
            JOB_ERR: err = head_job.err;
            JOB_MOV: begin
                if (step_reg == 2'd0) begin
                    kind      = STMT_CONST;
                    has_ref   = 1'b1;
                    res_ref   = head_job.ref0;
                    imm       = head_job.imm;
                    last_step = 1'b0;
                end else begin
                    kind    = STMT_STORE;
                    reg_idx = head_job.reg_a;
                    op_a    = head_job.ref0;
                end
            end
            JOB_ALU: begin
                last_step = 1'b0;
                unique case (step_reg)
                    2'd0: begin
                        kind    = STMT_LOAD;
                        has_ref = 1'b1;
                        res_ref = head_job.ref0;
                        reg_idx = head_job.reg_a;
                    end
                    2'd1: begin
                        kind    = STMT_LOAD;
                        has_ref = 1'b1;
                        res_ref = head_job.ref1;
                        reg_idx = head_job.reg_b;
                    end
                    2'd2: begin
                        kind    = STMT_BINOP;
                        has_ref = 1'b1;
                        res_ref = head_job.ref2;
                        op_a    = head_job.ref0;
                        op_b    = head_job.ref1;
                        sub     = head_job.is_sub;
                    end
                    default: begin
                        kind      = STMT_STORE;
                        reg_idx   = head_job.reg_a;
                        op_a      = head_job.ref2;
                        last_step = 1'b1;
                    end
                endcase
            end
            default: ;
        endcase
    end

    assign load = !m_tvalid_reg || m_tready;
    assign pop  = load && head_valid && last_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            step_reg     <= 2'd0;
        end else if (load) begin
            m_tvalid_reg <= head_valid;
            if (head_valid) begin
                step_reg <= last_step ? 2'd0 : step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && head_valid) begin
            m_tdata_reg <= {5'b0, err, head_job.len, imm, sub, op_b, op_a,
                            reg_idx, res_ref, has_ref};
            m_tuser_reg <= kind;
            m_tlast_reg <= last_step;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== src/x86_subset_instruction_decoder_unit.sv =====
// x86 subset instruction decoder: top level with APB register port.
// Instantiates xdec_front, xdec_fifo and xdec_back; depends on xdec_pkg.
//
// Usage:
//   s_ channel: one code byte per beat in s_tdata, s_tlast marks the last
//   byte of the buffer. m_ channel: one IR statement (or one error result)
//   per beat; m_tlast closes the run of an instruction.
//   APB: register first_ref at address 0; a write also loads the
//   reference counter. Write only while the block is idle.
// Timing:
//   A byte is taken every cycle while the job queue has room. The job of
//   an instruction's last byte is queued and its first beat is then
//   registered in the output stage; the back end delivers one beat per
//   cycle while m_tready is high, so an ADD/SUB (3 bytes, 4 beats) is
//   bounded by this expansion, absorbed by the 4-entry job queue.
// Reset: aresetn (synchronous, low) empties queue and output stage,
//   returns the decoder to the first-byte state and the counter to 0.
// Stall: while m_tready is low the output register holds; the queue fills
//   and s_tready drops once it is full.
module x86_subset_instruction_decoder_unit
    import xdec_pkg::*;
#(
    parameter int REF_WIDTH = REF_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // s_tdata: [7:0] code_byte
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tlast,
    // m_tdata: [0] has_ref, [32:1] result_ref, [35:33] reg_index,
    // [67:36] first_operand_ref, [99:68] second_operand_ref, [100] is_sub,
    // [164:101] immediate, [168:165] length_bytes, [170:169] error_code
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: [2:0] stmt_kind
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [31:0] first_ref_reg;
    logic        cfg_load;
    logic        byte_accept;
    logic        push, pop, full, head_valid;
    job_t        push_job, head_job;

    assign pready      = 1'b1;
    assign cfg_load    = psel && penable && pwrite && pready && (paddr[2] == REG_FIRST_REF);
    assign prdata      = (paddr[2] == REG_FIRST_REF) ? first_ref_reg : 32'd0;
    assign s_tready    = !full;
    assign byte_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_ref_reg <= 32'd0;
        end else if (cfg_load) begin
            first_ref_reg <= pwdata;
        end
    end

    xdec_front #(
        .REF_WIDTH (REF_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .code_byte   (s_tdata),
        .is_last     (s_tlast),
        .cfg_load    (cfg_load),
        .cfg_value   (pwdata),
        .push        (push),
        .job         (push_job)
    );

    xdec_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    xdec_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for x86_subset_instruction_decoder_unit: code bytes in, IR statements out.
// Uses xdec_pkg for codes and widths. Expected statements come from a built-in decode model.
`timescale 1ns / 1ps

module tb_top;
    import xdec_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  kind;
        logic        has_ref;
        logic [31:0] res_ref;
        logic [2:0]  reg_idx;
        logic [31:0] op_a;
        logic [31:0] op_b;
        logic        sub;
        logic [63:0] imm;
        logic [3:0]  len;
        logic [1:0]  err;
        logic        last;
    } stmt_t;

    // pinned rows carry a hand-written single-beat result (error or bare RET)
    typedef struct packed {
        logic [7:0] code;
        logic       eob;
        logic       pinned;
        logic [1:0] err;
        logic [3:0] len;
    } row_t;

    row_t dir_tbl [0:30] = '{
        '{8'hC3, 1'b0, 1'b1, ERR_NONE,    4'd1},
        '{8'h48, 1'b1, 1'b1, ERR_TRUNC,   4'd1},   // prefix ends the buffer
        '{8'h41, 1'b0, 1'b1, ERR_UNSUP,   4'd1},   // REX.B set
        '{8'h48, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hC3, 1'b0, 1'b1, ERR_UNSUP,   4'd2},   // RET behind a prefix
        '{8'hB8, 1'b0, 1'b1, ERR_UNSUP,   4'd1},   // MOV without REX.W
        '{8'h48, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'h4F, 1'b0, 1'b1, ERR_UNKNOWN, 4'd2},   // second prefix is an opcode
        '{8'h90, 1'b0, 1'b1, ERR_UNKNOWN, 4'd1},
        '{8'h48, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hBF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b1, 1'b0, ERR_NONE,    4'd0},   // buffer ends exactly on completion
        '{8'h48, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'h01, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hC0, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'h48, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'h29, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hFF, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'h48, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'h29, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'h3F, 1'b0, 1'b1, ERR_UNSUP,   4'd3},   // memory-form ModR/M
        '{8'h48, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'hB8, 1'b0, 1'b0, ERR_NONE,    4'd0},
        '{8'h00, 1'b1, 1'b1, ERR_TRUNC,   4'd3}    // immediate cut short
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    x86_subset_instruction_decoder_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // decode model state
    phase_t      ph;
    logic        rex_seen;
    logic        rex_w;
    logic [2:0]  mov_reg;
    logic        alu_sub;
    logic [63:0] imm_acc;
    logic [3:0]  imm_cnt;
    logic [3:0]  ilen;
    logic [31:0] ref_ctr;
    stmt_t       run_buf [0:3];

    stmt_t pending_stmts [$];
    int    snd_idle;
    int    rcv_idle;
    int    n_fail;
    int    n_beats;
    int    n_bytes;
    int    n_cycles;

    function automatic stmt_t mk_stmt(logic [2:0] kind, logic has, logic [31:0] res,
                                      logic [2:0] rg, logic [31:0] a, logic [31:0] b,
                                      logic sub, logic [63:0] imm, logic [1:0] err,
                                      logic last);
        stmt_t s;
        s = '{kind, has, res, rg, a, b, sub, imm, ilen, err, last};
        return s;
    endfunction

    function automatic void reset_decode();
        ph       = PH_FIRST;
        rex_seen = 1'b0;
        rex_w    = 1'b0;
        mov_reg  = 3'd0;
        alu_sub  = 1'b0;
        imm_acc  = 64'd0;
        imm_cnt  = 4'd0;
        ilen     = 4'd0;
    endfunction

    function automatic int abort_instr(logic [1:0] err);
        run_buf[0] = mk_stmt(STMT_RET, 1'b0, 32'd0, 3'd0, 32'd0, 32'd0, 1'b0, 64'd0, err, 1'b1);
        reset_decode();
        return 1;
    endfunction

    function automatic int decode_opcode(logic [7:0] b, logic eob);
        if (b == OP_RET) begin
            if (rex_seen)
                return abort_instr(ERR_UNSUP);
            run_buf[0] = mk_stmt(STMT_RET, 1'b0, 32'd0, 3'd0, 32'd0, 32'd0, 1'b0, 64'd0,
                                 ERR_NONE, 1'b1);
            reset_decode();
            return 1;
        end
        if (b >= OP_MOV_LO && b <= OP_MOV_HI) begin
            if (!rex_w)
                return abort_instr(ERR_UNSUP);
            if (eob)
                return abort_instr(ERR_TRUNC);
            mov_reg = b[2:0];
            imm_acc = 64'd0;
            imm_cnt = 4'd0;
            ph      = PH_IMM;
            return 0;
        end
        if (b == OP_ADD || b == OP_SUB) begin
            if (!rex_w)
                return abort_instr(ERR_UNSUP);
            if (eob)
                return abort_instr(ERR_TRUNC);
            alu_sub = (b == OP_SUB);
            ph      = PH_MODRM;
            return 0;
        end
        return abort_instr(ERR_UNKNOWN);
    endfunction

    // advance the decode model by one byte; fills run_buf, returns beat count
    function automatic int decode_byte(logic [7:0] b, logic eob);
        logic [31:0] rd;
        logic [31:0] rs;
        logic [31:0] rr;
        if (ilen < 4'd15)
            ilen++;
        unique case (ph)
            PH_FIRST: begin
                if ((b & REX_MASK) == REX_TAG) begin
                    if (eob)
                        return abort_instr(ERR_TRUNC);
                    if ((b & REX_RXB) != 8'd0)
                        return abort_instr(ERR_UNSUP);
                    rex_seen = 1'b1;
                    rex_w    = b[REX_W_BIT];
                    ph       = PH_OPCODE;
                    return 0;
                end
                return decode_opcode(b, eob);
            end
            PH_OPCODE: return decode_opcode(b, eob);
            PH_IMM: begin
                imm_acc |= 64'(b) << (8 * imm_cnt);
                imm_cnt++;
                if (imm_cnt < 4'd8) begin
                    if (eob)
                        return abort_instr(ERR_TRUNC);
                    return 0;
                end
                rd = ref_ctr;
                ref_ctr++;
                run_buf[0] = mk_stmt(STMT_CONST, 1'b1, rd, 3'd0, 32'd0, 32'd0, 1'b0, imm_acc,
                                     ERR_NONE, 1'b0);
                run_buf[1] = mk_stmt(STMT_STORE, 1'b0, 32'd0, mov_reg, rd, 32'd0, 1'b0, 64'd0,
                                     ERR_NONE, 1'b1);
                reset_decode();
                return 2;
            end
            default: begin
                if (b[7:6] != MOD_REG)
                    return abort_instr(ERR_UNSUP);
                rd = ref_ctr;
                rs = ref_ctr + 32'd1;
                rr = ref_ctr + 32'd2;
                ref_ctr += 32'd3;
                run_buf[0] = mk_stmt(STMT_LOAD, 1'b1, rd, b[2:0], 32'd0, 32'd0, 1'b0, 64'd0,
                                     ERR_NONE, 1'b0);
                run_buf[1] = mk_stmt(STMT_LOAD, 1'b1, rs, b[5:3], 32'd0, 32'd0, 1'b0, 64'd0,
                                     ERR_NONE, 1'b0);
                run_buf[2] = mk_stmt(STMT_BINOP, 1'b1, rr, 3'd0, rd, rs, alu_sub, 64'd0,
                                     ERR_NONE, 1'b0);
                run_buf[3] = mk_stmt(STMT_STORE, 1'b0, 32'd0, b[2:0], rr, 32'd0, 1'b0, 64'd0,
                                     ERR_NONE, 1'b1);
                reset_decode();
                return 4;
            end
        endcase
    endfunction

    function automatic string fmt_stmt(stmt_t s);
        return {$sformatf("kind=%0d has=%0d ref=%h reg=%0d a=%h b=%h",
                          s.kind, s.has_ref, s.res_ref, s.reg_idx, s.op_a, s.op_b),
                $sformatf(" sub=%0d imm=%h len=%0d err=%0d last=%0d",
                          s.sub, s.imm, s.len, s.err, s.last)};
    endfunction

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding", n_cycles,
                     pending_stmts.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= rcv_idle);

    // output monitor
    always @(posedge aclk) begin
        stmt_t got;
        stmt_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser[2:0], m_tdata[0], m_tdata[32:1], m_tdata[35:33], m_tdata[67:36],
                    m_tdata[99:68], m_tdata[100], m_tdata[164:101], m_tdata[168:165],
                    m_tdata[170:169], m_tlast};
            n_beats++;
            if (pending_stmts.size() == 0) begin
                if (n_fail < 10)
                    $display("beat %0d with nothing pending: %s", n_beats, fmt_stmt(got));
                n_fail++;
            end else begin
                want = pending_stmts.pop_front();
                if (got !== want) begin
                    if (n_fail < 10) begin
                        $display("beat %0d mismatch", n_beats);
                        $display("  exp %s", fmt_stmt(want));
                        $display("  got %s", fmt_stmt(got));
                    end
                    n_fail++;
                end
            end
        end
    end

    // enters and leaves on a falling edge; s_tvalid stays up for back-to-back bytes
    task automatic send_byte(input logic [7:0] b, input logic eob, input logic pinned,
                             input stmt_t pin_exp);
        int n;
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eob;
        do @(posedge aclk); while (!s_tready);
        n = decode_byte(b, eob);
        if (pinned)
            pending_stmts.insert(pending_stmts.size(), pin_exp);
        else
            for (int i = 0; i < n; i++)
                pending_stmts.insert(pending_stmts.size(), run_buf[i]);
        n_bytes++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_stmts.size() != 0)
            @(negedge aclk);
    endtask

    task automatic set_first_ref(input logic [31:0] v);
        drain();
        repeat (12) @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FIRST_REF, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        ref_ctr = v;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== v) begin
            if (n_fail < 10)
                $display("first_ref readback %h, wrote %h", prdata, v);
            n_fail++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly well-formed instructions with random content, some noise and odd prefixes
    task automatic send_random_instr();
        logic [7:0] seq [$];
        int         pick;
        int         pr;
        logic       eob;
        pick = $urandom_range(99);
        pr   = $urandom_range(99);
        if (pick < 15) begin
            if (pr < 10)
                seq.insert(seq.size(), REX_TAG | 8'($urandom_range(15)));
            seq.insert(seq.size(), OP_RET);
        end else if (pick < 80) begin
            if (pr < 78)
                seq.insert(seq.size(), REX_TAG | 8'h08);
            else if (pr >= 88)
                seq.insert(seq.size(), REX_TAG | 8'($urandom_range(15)));
            if (pick < 45) begin
                seq.insert(seq.size(), OP_MOV_LO + 8'($urandom_range(7)));
                repeat (8) seq.insert(seq.size(), 8'($urandom_range(255)));
            end else begin
                seq.insert(seq.size(), ($urandom_range(1) != 0) ? OP_SUB : OP_ADD);
                if ($urandom_range(99) < 85)
                    seq.insert(seq.size(), {MOD_REG, 6'($urandom_range(63))});
                else
                    seq.insert(seq.size(), 8'($urandom_range(255)));
            end
        end else begin
            repeat ($urandom_range(3, 1)) seq.insert(seq.size(), 8'($urandom_range(255)));
        end
        foreach (seq[i]) begin
            if (i == seq.size() - 1)
                eob = ($urandom_range(99) < 15);
            else
                eob = ($urandom_range(99) < 3);
            send_byte(seq[i], eob, 1'b0, '0);
        end
    endtask

    task automatic run_random(input int target, input int pause_at);
        int  start;
        logic paused;
        start  = n_bytes;
        paused = 1'b0;
        while (n_bytes - start < target) begin
            if (pause_at > 0 && !paused && n_bytes - start >= pause_at) begin
                drain();
                paused = 1'b1;
            end
            send_random_instr();
        end
    endtask

    initial begin
        stmt_t pin;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'd0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        n_fail   = 0;
        n_beats  = 0;
        n_bytes  = 0;
        n_cycles = 0;
        ref_ctr  = 32'd0;
        reset_decode();
        snd_idle = 11;
        rcv_idle = 74;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tbl[i]) begin
            pin      = '0;
            pin.kind = STMT_RET;
            pin.len  = dir_tbl[i].len;
            pin.err  = dir_tbl[i].err;
            pin.last = 1'b1;
            send_byte(dir_tbl[i].code, dir_tbl[i].eob, dir_tbl[i].pinned, pin);
        end

        // counter about to wrap
        set_first_ref(32'hFFFF_FFFE);
        run_random(48, 0);

        snd_idle = 74;
        rcv_idle = 11;
        set_first_ref(32'hFFFF_FFFF);
        run_random(48, 30);

        snd_idle = 0;
        rcv_idle = 0;
        set_first_ref($urandom);
        run_random(48, 0);

        set_first_ref(32'd0);
        run_random(46, 0);

        drain();
        repeat (20) @(negedge aclk);
        $display("%0d code bytes in, %0d statement beats checked; first_ref loads at both",
                 n_bytes, n_beats);
        $display("extremes, wrap and random, under three sender/receiver stall mixes");
        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
